FILE: rtl/ltfc_pkg.sv
// Shared types and constants for the lap timer frame checker.
package ltfc_pkg;

	// Frame layout, in byte positions counted from zero.
	localparam int unsigned FRAME_BYTES = 17;
	localparam int unsigned POS_W       = 5;

	localparam logic [POS_W-1:0] SUM_FIRST = POS_W'(2);
	localparam logic [POS_W-1:0] LAPS_POS  = POS_W'(10);
	localparam logic [POS_W-1:0] SEC_FIRST = POS_W'(11);
	localparam logic [POS_W-1:0] SEC_LAST  = POS_W'(13);
	localparam logic [POS_W-1:0] MS_FIRST  = POS_W'(14);
	localparam logic [POS_W-1:0] MS_LAST   = POS_W'(15);
	localparam logic [POS_W-1:0] CHECK_POS = POS_W'(FRAME_BYTES - 1);
	localparam logic [POS_W-1:0] POS_SAT   = POS_W'(FRAME_BYTES + 1);

	localparam int unsigned SEC_W  = 24;
	localparam int unsigned MSEC_W = 16;
	localparam int unsigned TIME_W = 34;
	localparam int unsigned MULT_W = 10;

	localparam logic [MULT_W-1:0] MS_PER_SEC = MULT_W'(1000);

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_LENGTH   = 2'd1,
		STATUS_CHECKSUM = 2'd2
	} status_t;

	// One received byte.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} rx_item_t;

	// One frame result as delivered.
	typedef struct packed {
		status_t           frame_status;
		logic [7:0]        lap_num;
		logic [TIME_W-1:0] lap_time_ms;
	} res_item_t;

	// Parsed frame handed from the parser to the time stage.
	typedef struct packed {
		status_t           status;
		logic [7:0]        laps;
		logic [SEC_W-1:0]  seconds;
		logic [MSEC_W-1:0] millis;
	} frame_t;

endpackage

FILE: rtl/lap_timer_frame_checker.sv
// Top level of the lap timer frame checker.
// Throughput: one byte per cycle while the result side keeps up; any byte stalls while a
// frame result waits in the parser behind a held output register.
// A frame result passes the parser result register, loaded as its last byte transfers, then
// the multiply-add output register, loaded once the output register is free.
// Reset clears the byte count, checksum, captured fields and both valid flags.
module lap_timer_frame_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rx_valid,
	output logic                rx_stall,
	input  ltfc_pkg::rx_item_t  rx_item,
	output logic                res_valid,
	input  logic                res_stall,
	output ltfc_pkg::res_item_t res_item
);
	import ltfc_pkg::*;

	logic   frame_valid_s1;
	frame_t frame_s1;
	logic   frame_take;

	ltfc_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_valid       (rx_valid),
		.rx_stall       (rx_stall),
		.rx_item        (rx_item),
		.frame_valid_s1 (frame_valid_s1),
		.frame_s1       (frame_s1),
		.frame_take     (frame_take)
	);

	ltfc_time_calc u_time_calc (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame_valid_s1 (frame_valid_s1),
		.frame_s1       (frame_s1),
		.frame_take     (frame_take),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.res_item       (res_item)
	);

	// Input is held back only by a waiting frame result.
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_valid_s1 |-> !rx_stall)
		else $error("input stalled with empty result register");

	// A transferred last byte always yields a frame result.
	a_last_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_valid && !rx_stall && rx_item.last_byte) |=> frame_valid_s1)
		else $error("last byte did not produce a frame result");

	// Rejected frames carry zero fields.
	a_bad_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_item.frame_status != STATUS_OK)
		|-> (res_item.lap_num == '0 && res_item.lap_time_ms == '0))
		else $error("rejected frame with nonzero fields");

endmodule

FILE: rtl/ltfc_parser.sv
// Byte parser: counts, sums and captures frame fields, and registers one frame result.
module ltfc_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	output logic              rx_stall,
	input  ltfc_pkg::rx_item_t rx_item,
	output logic              frame_valid_s1,
	output ltfc_pkg::frame_t  frame_s1,
	input  logic              frame_take
);
	import ltfc_pkg::*;

	logic [POS_W-1:0]  pos_q, pos_d;
	logic [7:0]        sum_q, sum_d;
	logic [7:0]        laps_q, laps_d;
	logic [SEC_W-1:0]  sec_q, sec_d;
	logic [MSEC_W-1:0] ms_q, ms_d;
	logic              xfer;
	frame_t            frame_d;

	// The result register blocks new bytes only while it holds an untaken frame.
	assign rx_stall = frame_valid_s1 && !frame_take;
	assign xfer     = rx_valid && !rx_stall;

	// Field capture and running checksum for the current byte.
	always_comb begin
		pos_d  = pos_q;
		sum_d  = sum_q;
		laps_d = laps_q;
		sec_d  = sec_q;
		ms_d   = ms_q;
		if (pos_q >= SUM_FIRST && pos_q < CHECK_POS) begin
			sum_d = sum_q + rx_item.data_byte;
		end
		if (pos_q == LAPS_POS) begin
			laps_d = rx_item.data_byte;
		end
		if (pos_q >= SEC_FIRST && pos_q <= SEC_LAST) begin
			sec_d = {sec_q[SEC_W-9:0], rx_item.data_byte};
		end
		if (pos_q >= MS_FIRST && pos_q <= MS_LAST) begin
			ms_d = {ms_q[MSEC_W-9:0], rx_item.data_byte};
		end
		if (pos_q < POS_SAT) begin
			pos_d = pos_q + POS_W'(1);
		end
		// The last byte ends the frame and everything starts over.
		if (rx_item.last_byte) begin
			pos_d  = '0;
			sum_d  = '0;
			laps_d = '0;
			sec_d  = '0;
			ms_d   = '0;
		end
	end

	// Frame verdict; the fields are zero unless the frame checks out.
	always_comb begin
		frame_d = '0;
		if (pos_q != CHECK_POS) begin
			frame_d.status = STATUS_LENGTH;
		end else if (rx_item.data_byte != sum_q) begin
			frame_d.status = STATUS_CHECKSUM;
		end else begin
			frame_d.status  = STATUS_OK;
			frame_d.laps    = laps_q;
			frame_d.seconds = sec_q;
			frame_d.millis  = ms_q;
		end
	end

	// Frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			sum_q  <= '0;
			laps_q <= '0;
			sec_q  <= '0;
			ms_q   <= '0;
		end else if (xfer) begin
			pos_q  <= pos_d;
			sum_q  <= sum_d;
			laps_q <= laps_d;
			sec_q  <= sec_d;
			ms_q   <= ms_d;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_s1 <= 1'b0;
		end else if (xfer && rx_item.last_byte) begin
			frame_valid_s1 <= 1'b1;
		end else if (frame_take) begin
			frame_valid_s1 <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (xfer && rx_item.last_byte) begin
			frame_s1 <= frame_d;
		end
	end

endmodule

FILE: rtl/ltfc_time_calc.sv
// Output stage: converts seconds and milliseconds to a millisecond count.
module ltfc_time_calc (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               frame_valid_s1,
	input  ltfc_pkg::frame_t   frame_s1,
	output logic               frame_take,
	output logic               res_valid,
	input  logic               res_stall,
	output ltfc_pkg::res_item_t res_item
);
	import ltfc_pkg::*;

	logic [TIME_W-1:0] prod;
	logic [TIME_W-1:0] time_ms;
	logic              out_free;

	// The output register can load when empty or when its transfer completes.
	assign out_free   = !res_valid || !res_stall;
	assign frame_take = frame_valid_s1 && out_free;

	// Seconds times 1000 fits exactly in 34 bits.
	assign prod    = {{(TIME_W-SEC_W){1'b0}}, frame_s1.seconds}
	               * {{(TIME_W-MULT_W){1'b0}}, MS_PER_SEC};
	assign time_ms = prod + {{(TIME_W-MSEC_W){1'b0}}, frame_s1.millis};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (out_free) begin
			res_valid <= frame_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_take) begin
			res_item.frame_status <= frame_s1.status;
			res_item.lap_num      <= frame_s1.laps;
			res_item.lap_time_ms  <= time_ms;
		end
	end

endmodule

FILE: verif/tb_lap_timer_frame_checker.sv
// Testbench for the lap timer frame checker: random serial frames checked against a predictor.
`timescale 1ns / 1ps

module tb_lap_timer_frame_checker;
	import ltfc_pkg::*;

	localparam int STREAM_BYTES = 1500;
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 10;
	localparam int MAX_REPORTS  = 10;

	// Tracks the frame parser state and queues the frame result each last byte produces.
	class frame_scoreboard;
		logic [4:0]  pos;
		logic [7:0]  sum;
		logic [7:0]  laps;
		logic [23:0] secs;
		logic [15:0] msecs;
		res_item_t   pending[$];
		int          errors;

		function new();
			errors = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			pos   = '0;
			sum   = '0;
			laps  = '0;
			secs  = '0;
			msecs = '0;
		endfunction

		// Absorb one accepted byte; on the last byte of a frame, queue its result.
		function void note_byte(rx_item_t it);
			logic [4:0] p;
			res_item_t  r;
			p = pos;
			if (p >= SUM_FIRST && p < CHECK_POS) begin
				sum = sum + it.data_byte;
			end
			if (p == LAPS_POS) begin
				laps = it.data_byte;
			end
			if (p >= SEC_FIRST && p <= SEC_LAST) begin
				secs = {secs[15:0], it.data_byte};
			end
			if (p >= MS_FIRST && p <= MS_LAST) begin
				msecs = {msecs[7:0], it.data_byte};
			end
			if (p < POS_SAT) begin
				pos = p + 5'd1;
			end
			if (!it.last_byte) begin
				return;
			end
			r = '0;
			if (p != CHECK_POS) begin
				r.frame_status = STATUS_LENGTH;
			end else if (it.data_byte != sum) begin
				r.frame_status = STATUS_CHECKSUM;
			end else begin
				r.frame_status = STATUS_OK;
				r.lap_num      = laps;
				r.lap_time_ms  = 34'(secs) * 34'd1000 + 34'(msecs);
			end
			pending.push_back(r);
			clear_frame();
		endfunction

		// Compare one accepted result with the oldest pending frame result.
		function void check_result(res_item_t got);
			res_item_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("%0t: result with no frame pending: status %0d laps %0d ms %0d",
						$realtime, got.frame_status, got.lap_num, got.lap_time_ms);
				end
				return;
			end
			want = pending.pop_front();
			if (got.frame_status != want.frame_status || got.lap_num != want.lap_num ||
					got.lap_time_ms != want.lap_time_ms) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("%0t: mismatch: expected status %0d laps %0d ms %0d, got %0d %0d %0d",
						$realtime, want.frame_status, want.lap_num, want.lap_time_ms,
						got.frame_status, got.lap_num, got.lap_time_ms);
				end
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      rx_valid;
	logic      rx_stall;
	rx_item_t  rx_item;
	logic      res_valid;
	logic      res_stall;
	res_item_t res_item;

	frame_scoreboard sb;
	logic [7:0]      frame_bytes[$];
	bit              hold_req;
	int              idle_cycles;
	int              sent_bytes;

	lap_timer_frame_checker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_item  (rx_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item (res_item)
	);

	always #6 clk = ~clk;

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Fill frame_bytes; a negative fill gives random content. A 17-byte frame gets a
	// correct checksum unless bad_sum asks for a corrupted one.
	task automatic build_frame(input int len, input bit bad_sum, input int fill);
		logic [7:0] s;
		logic [7:0] v;
		frame_bytes.delete();
		s = '0;
		for (int i = 0; i < len; i++) begin
			v = (fill < 0) ? 8'($urandom) : 8'(fill);
			if (i >= 2 && i <= 15) begin
				s = s + v;
			end
			if (i == 16 && len == 17) begin
				v = bad_sum ? (s ^ 8'($urandom_range(1, 255))) : s;
			end
			frame_bytes.push_back(v);
		end
	endtask

	// Offer one byte after an optional gap and hold it until the transfer happens.
	task automatic send_byte(input rx_item_t it, input int gap);
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_item  <= it;
		do @(posedge clk); while (rx_stall);
		sent_bytes++;
	endtask

	task automatic send_frame(input bit tight);
		rx_item_t it;
		foreach (frame_bytes[i]) begin
			it.data_byte = frame_bytes[i];
			it.last_byte = (i == frame_bytes.size() - 1);
			send_byte(it, tight ? 0 : pick_gap());
		end
	endtask

	// Random frame: mostly well formed, some with a bad checksum, some of the wrong length.
	task automatic random_frame(input bit short_only);
		int r;
		int len;
		r = $urandom_range(0, 99);
		if (short_only) begin
			build_frame($urandom_range(1, 4), 1'b0, -1);
		end else if (r < 70) begin
			build_frame(17, 1'b0, -1);
		end else if (r < 82) begin
			build_frame(17, 1'b1, -1);
		end else begin
			len = $urandom_range(1, 39);
			if (len >= 17) begin
				len++;
			end
			build_frame(len, 1'b0, -1);
		end
	endtask

	// Receiver: random stall stretches, plus one long hold-off on request.
	initial begin
		int n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				n = pick_gap();
				if (n > 0) begin
					res_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
				res_stall <= 1'b0;
				repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
						: $urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// Transfer monitor and watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_valid && !rx_stall) || (res_valid && !res_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (rx_valid && !rx_stall) begin
				sb.note_byte(rx_item);
			end
			if (res_valid && !res_stall) begin
				sb.check_result(res_item);
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL lap_timer_frame_checker");
				$finish;
			end
		end
	end

	// Main sequence.
	initial begin
		bit pressed;
		clk         = 1'b0;
		arst_n      = 1'b0;
		rx_valid    = 1'b0;
		rx_item     = '0;
		res_stall   = 1'b0;
		hold_req    = 1'b0;
		idle_cycles = 0;
		sent_bytes  = 0;
		pressed     = 1'b0;
		sb          = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Largest lap number and lap time, with a good checksum.
		build_frame(17, 1'b0, 255);
		send_frame(1'b0);
		// All-zero content with a corrupted checksum.
		build_frame(17, 1'b1, 0);
		send_frame(1'b0);
		// A frame that ends on its first byte, and one a byte short.
		build_frame(1, 1'b0, -1);
		send_frame(1'b1);
		build_frame(16, 1'b0, -1);
		send_frame(1'b0);

		// Random frames; midway the receiver holds off while short frames keep coming.
		while (sent_bytes < STREAM_BYTES) begin
			if (!pressed && sent_bytes >= STREAM_BYTES / 2) begin
				pressed  = 1'b1;
				hold_req = 1'b1;
				repeat (25) begin
					random_frame(1'b1);
					send_frame(1'b1);
				end
			end
			random_frame(1'b0);
			send_frame($urandom_range(0, 3) == 0);
		end
		rx_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASS lap_timer_frame_checker");
		end else begin
			$display("FAIL lap_timer_frame_checker");
		end
		$finish;
	end

endmodule
